/* hdl/rrs_pkg.sv */
// shared types, constants and codes of the relocation run scanner
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int RECORD_WORDS    = 3;
  localparam int RECORD_BYTES    = RECORD_WORDS * 8;
  localparam int COUNT_W         = 28;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN     = 2'd2;

  // register reset values
  localparam logic [31:0]        RECORD_TYPE_RST = 32'd8;
  localparam logic [31:0]        SCAN_LIMIT_RST  = 32'd67108864;
  localparam logic [COUNT_W-1:0] MIN_RUN_RST     = 28'd1000;

  // scan mode codes: searching and judging the next record; the codes between mean inside a record
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_JUDGE  = 2'(RECORD_WORDS);

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [63:0] file_word;
    logic        is_last;
  } in_word_t;

  typedef struct packed {
    logic               table_found;
    logic [31:0]        run_start_offset;
    logic [COUNT_W-1:0] run_length;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        record_type;
    logic [31:0]        scan_limit;
    logic [COUNT_W-1:0] min_run;
  } cfg_t;

  // one classified word, as handed from front to back
  typedef struct packed {
    logic [63:0] offset;     // first word of the record ending here
    logic [31:0] start;      // byte offset of that record
    logic        type_ok;    // second word matches the record type
    logic        cand_ok;    // record may open a new run
    logic        search_ok;  // a full record is in the window
    logic        last;
  } class_t;

endpackage

/* hdl/rrs_front.sv */
// front end: word window, position counter and per-word record classification
`timescale 1ns / 1ps

module rrs_front import rrs_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_word_t in_word_i,
  input  logic     push_i,
  output class_t   entry_o
);

  localparam int CW = (OFFSET_BITS + 4 > 33) ? OFFSET_BITS + 4 : 33;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [63:0]            w1_q, w2_q;
  logic [CW-1:0]          pos_ext, start_ext, end_ext, limit_ext;
  logic                   pos_sat, type_ok;

  assign pos_ext   = CW'(pos_q);
  assign start_ext = CW'((pos_ext - CW'(RECORD_WORDS - 1)) << 3);
  assign end_ext   = start_ext + CW'(RECORD_BYTES);
  assign limit_ext = CW'(cfg_i.scan_limit);
  assign pos_sat   = &pos_q;
  // window after this word: w1_q, w2_q, incoming word
  assign type_ok   = (w2_q == {32'b0, cfg_i.record_type});

  always_comb begin
    entry_o.offset    = w1_q;
    entry_o.start     = start_ext[31:0];
    entry_o.type_ok   = type_ok;
    entry_o.search_ok = (pos_q >= OFFSET_BITS'(RECORD_WORDS - 1));
    entry_o.cand_ok   = !pos_sat && (end_ext <= limit_ext) && type_ok && !w1_q[63]
                        && entry_o.search_ok;
    entry_o.last      = in_word_i.is_last;
  end

  always_comb begin
    pos_d = pos_q;
    if (in_word_i.is_last) begin
      pos_d = '0;
    end else if (!pos_sat) begin
      pos_d = pos_q + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_i) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      w1_q <= w2_q;
      w2_q <= in_word_i.file_word;
    end
  end

endmodule

/* hdl/rrs_queue.sv */
// two-entry queue of classified words between front and back
`timescale 1ns / 1ps

module rrs_queue import rrs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  class_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   valid_o,
  output class_t head_o
);

  class_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, rd_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

/* hdl/rrs_back.sv */
// back end: run tracking, best run bookkeeping and result register
`timescale 1ns / 1ps

module rrs_back import rrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] min_run_i,
  input  logic               q_valid_i,
  input  class_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output out_word_t          out_word_o,
  input  logic               out_stall_i
);

  logic [1:0]         mode_q, mode_d;
  logic [31:0]        run_start_q, run_start_d, best_start_q, best_start_d;
  logic [COUNT_W-1:0] run_count_q, run_count_d, best_cnt_q, best_cnt_d;
  logic [63:0]        prev_q, prev_d;
  logic               out_valid_q;
  out_word_t          out_q;
  logic               extend;

  // a last word needs the result register free
  assign pop_o = q_valid_i && !(head_i.last && out_valid_q && out_stall_i);

  assign extend = head_i.type_ok && ($signed(head_i.offset) > $signed(prev_q));

  always_comb begin
    mode_d      = mode_q;
    run_start_d = run_start_q;
    run_count_d = run_count_q;
    prev_d      = prev_q;
    case (mode_q)
      MODE_SEARCH, MODE_JUDGE: begin
        if (mode_q == MODE_JUDGE && extend) begin
          if (run_count_q != COUNT_MAX) begin
            run_count_d = run_count_q + COUNT_W'(1);
          end
          prev_d = head_i.offset;
          mode_d = 2'(1);
        end else if (mode_q == MODE_JUDGE || head_i.search_ok) begin
          if (head_i.cand_ok) begin
            run_start_d = head_i.start;
            run_count_d = COUNT_W'(1);
            prev_d      = head_i.offset;
            mode_d      = 2'(1);
          end else begin
            run_count_d = '0;
            prev_d      = '1;
            mode_d      = MODE_SEARCH;
          end
        end
      end
      default: begin
        mode_d = mode_q + 2'(1);
      end
    endcase
    best_cnt_d   = best_cnt_q;
    best_start_d = best_start_q;
    if (run_count_d > best_cnt_q) begin
      best_cnt_d   = run_count_d;
      best_start_d = run_start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_SEARCH;
      run_start_q  <= '0;
      run_count_q  <= '0;
      prev_q       <= '1;
      best_start_q <= '0;
      best_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (head_i.last) begin
          mode_q       <= MODE_SEARCH;
          run_start_q  <= '0;
          run_count_q  <= '0;
          prev_q       <= '1;
          best_start_q <= '0;
          best_cnt_q   <= '0;
          out_valid_q  <= 1'b1;
        end else begin
          mode_q       <= mode_d;
          run_start_q  <= run_start_d;
          run_count_q  <= run_count_d;
          prev_q       <= prev_d;
          best_start_q <= best_start_d;
          best_cnt_q   <= best_cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      out_q.table_found      <= (best_cnt_d >= min_run_i);
      out_q.run_start_offset <= best_start_d;
      out_q.run_length       <= best_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* hdl/relocation_run_scanner_top.sv */
// top level of the relocation run scanner
`timescale 1ns / 1ps

// usage
//   input channel: one 64-bit file word per word, in file order, is_last on
//   the final word; words are taken whenever in_valid_i is high and
//   in_stall_o is low
//   output channel: exactly one result word per file, after the last word:
//   earliest longest run (start byte offset, record count) and table_found
//   throughput: one word per cycle while in_stall_o is low; the front
//   classifies each word against a three-word window as it is taken, the
//   back updates the run state one queued word per cycle while it can pop
//   result path: the last word passes the queue, then the output register
//   receiver stall: the result holds in the output register; the back then
//   halts only at the next last word, the two-entry queue fills and
//   in_stall_o rises while it is full
//   reset: registers return to 8, 64 MiB and 1000, scan state is cleared;
//   after each result the scan state clears again for the next file
//   configuration: plain write port; the user writes it only while no file
//   is in flight, and the block itself does not enforce this

module relocation_run_scanner_top import rrs_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input words
  input  logic                 in_valid_i,
  input  in_word_t             in_word_i,
  output logic                 in_stall_o,
  // result words
  output logic                 out_valid_o,
  output out_word_t            out_word_o,
  input  logic                 out_stall_i
);

  cfg_t   cfg_q;
  logic   push, q_full, q_valid, pop;
  class_t entry, head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_type <= RECORD_TYPE_RST;
      cfg_q.scan_limit  <= SCAN_LIMIT_RST;
      cfg_q.min_run     <= MIN_RUN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RECORD_TYPE: cfg_q.record_type <= cfg_data_i;
        CFG_SCAN_LIMIT:  cfg_q.scan_limit  <= cfg_data_i;
        CFG_MIN_RUN:     cfg_q.min_run     <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stall only while the queue is full
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  // window and classification of each taken word
  rrs_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_word_i (in_word_i),
    .push_i    (push),
    .entry_o   (entry)
  );

  // decouples the front from a stalled back
  rrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // run state machine and result register
  rrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_run_i   (cfg_q.min_run),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  // a taken word is always waiting in the queue at the next edge
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> q_valid)
    else $error("taken word missing from queue");

  // the found flag agrees with the reported length
  a_found_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.table_found == (out_word_o.run_length >= cfg_q.min_run)))
    else $error("table_found disagrees with run_length");

  // no run means a zero start offset
  a_empty_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.run_length == '0) |-> (out_word_o.run_start_offset == '0))
    else $error("start offset without a run");

  // the back never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
